### sv/isu_pkg.sv
// -----------------------------------------------------------------------------
// Insertion sorter package
// Shared types and default sizes for the insertion sorter cell chain.
// -----------------------------------------------------------------------------
package isu_pkg;

	// Default number of cells in the chain.
	localparam int unsigned DEPTH_DEF = 32;

	// Default width of a stored key.
	localparam int unsigned KEY_WIDTH_DEF = 32;

	// Fixed width of the key ports.
	localparam int unsigned KEY_PORT_W = 32;

	// Status that one cell hands to its neighbours.
	typedef struct packed {
		logic valid;    // cell holds a key
		logic greater;  // held key is strictly greater than the key being inserted
	} link_t;

endpackage

### sv/isu_cell.sv
// -----------------------------------------------------------------------------
// Insertion sorter cell
// One place of the sorted store. On an insert it either keeps its key, takes
// the key of its lower neighbour, or takes the new key; on a drain it takes the
// key of its upper neighbour.
// -----------------------------------------------------------------------------
module isu_cell #(
	parameter int unsigned KEY_WIDTH = isu_pkg::KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 insert,
	input  logic                 shift,
	input  logic [KEY_WIDTH-1:0] new_key,
	input  isu_pkg::link_t       lower_link,
	input  logic [KEY_WIDTH-1:0] lower_key,
	input  isu_pkg::link_t       upper_link,
	input  logic [KEY_WIDTH-1:0] upper_key,
	output isu_pkg::link_t       link,
	output logic [KEY_WIDTH-1:0] key
);

	logic                 valid_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic                 greater;
	logic                 take;

	// Strictly greater keys move up, so equal keys keep their arrival order.
	assign greater = valid_q && ($signed(new_key) < $signed(key_q));

	// The cell is rewritten when its key moves up, or when it is the first free place.
	assign take = greater || (!valid_q && lower_link.valid);

	assign link.valid   = valid_q;
	assign link.greater = greater;
	assign key          = key_q;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= upper_link.valid;
		end else if (insert) begin
			valid_q <= valid_q | lower_link.valid;
		end
	end

	// Stored key.
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= upper_key;
		end else if (insert && take) begin
			key_q <= lower_link.greater ? lower_key : new_key;
		end
	end

endmodule

### sv/insertion_sorter_unit.sv
// -----------------------------------------------------------------------------
// Insertion sorter unit
// Stable ascending insertion sort of signed key batches in a chain of cells.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid/in_ready  | key_value, end_of_batch
//   output  | out_valid/out_ready| sorted_key, final_key, dropped_keys
//
// An input key is inserted in parallel: every cell compares against it at once
// and the larger keys step up one cell. After a transaction marked end_of_batch,
// the chain drains one key per cycle from the lowest cell while out_ready is high,
// and in_ready stays low until the last key has been taken. Reset clears the cell
// occupancy flags and the drop flag; stored keys are not cleared.
// -----------------------------------------------------------------------------
module insertion_sorter_unit #(
	parameter int unsigned DEPTH     = isu_pkg::DEPTH_DEF,
	parameter int unsigned KEY_WIDTH = isu_pkg::KEY_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [isu_pkg::KEY_PORT_W-1:0] key_value,
	input  logic                               end_of_batch,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [isu_pkg::KEY_PORT_W-1:0] sorted_key,
	output logic                               final_key,
	output logic                               dropped_keys
);

	isu_pkg::link_t       links [DEPTH];
	logic [KEY_WIDTH-1:0] keys  [DEPTH];
	logic signed [63:0]   key_ext;
	logic signed [63:0]   out_ext;
	logic [KEY_WIDTH-1:0] new_key;
	logic                 in_fire;
	logic                 insert;
	logic                 shift;
	logic                 full;
	logic                 drain_q;
	logic                 overflow_q;

	// Input key taken as a KEY_WIDTH-bit two's complement value.
	assign key_ext = 64'(key_value);
	assign new_key = key_ext[KEY_WIDTH-1:0];

	// Handshake and chain control.
	assign in_ready  = !drain_q;
	assign in_fire   = in_valid && in_ready;
	assign full      = links[DEPTH-1].valid;
	assign insert    = in_fire && !full;
	assign out_valid = drain_q;
	assign shift     = out_valid && out_ready;

	// Results come straight from the lowest cell; the stored bits are passed
	// out as they are, zero-filled above the key width.
	assign out_ext      = 64'(keys[0]);
	assign sorted_key   = out_ext[isu_pkg::KEY_PORT_W-1:0];
	assign final_key    = !links[1].valid;
	assign dropped_keys = overflow_q;

	// Chain of cells: the lowest sees a valid, non-greater boundary below it,
	// the highest sees an empty place above it.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		isu_pkg::link_t       lower_link;
		logic [KEY_WIDTH-1:0] lower_key;
		isu_pkg::link_t       upper_link;
		logic [KEY_WIDTH-1:0] upper_key;

		if (i == 0) begin : g_bottom
			assign lower_link = '{valid: 1'b1, greater: 1'b0};
			assign lower_key  = new_key;
		end else begin : g_lower
			assign lower_link = links[i-1];
			assign lower_key  = keys[i-1];
		end

		if (i == DEPTH - 1) begin : g_top
			assign upper_link = '{valid: 1'b0, greater: 1'b0};
			assign upper_key  = keys[i];
		end else begin : g_upper
			assign upper_link = links[i+1];
			assign upper_key  = keys[i+1];
		end

		isu_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.insert     (insert),
			.shift      (shift),
			.new_key    (new_key),
			.lower_link (lower_link),
			.lower_key  (lower_key),
			.upper_link (upper_link),
			.upper_key  (upper_key),
			.link       (links[i]),
			.key        (keys[i])
		);
	end

	// Drain phase and sticky drop flag of the current batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else if (shift && final_key) begin
			drain_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else if (in_fire) begin
			if (full) begin
				overflow_q <= 1'b1;
			end
			if (end_of_batch) begin
				drain_q <= 1'b1;
			end
		end
	end

endmodule

### tb/insertion_sorter_unit_tb.sv
// -----------------------------------------------------------------------------
// Insertion sorter unit testbench
// Sends batches of signed keys through the sorter and checks that every batch
// comes back in ascending order with the last and overflow marks right. A
// behavioural store of the sorter predicts each batch. Both channels idle at
// random, the receiver holds off once for a long stretch, and batches that fill
// or overrun the store are included.
// -----------------------------------------------------------------------------
module insertion_sorter_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH     = isu_pkg::DEPTH_DEF;
	localparam int unsigned KW        = isu_pkg::KEY_PORT_W;
	localparam int unsigned RAND_KEYS = 350;
	localparam int unsigned HOLD_AT   = 400;
	localparam int unsigned HOLD_LEN  = 300;
	localparam int unsigned CALM_FROM = 700;
	localparam int unsigned CALM_TO   = 1100;
	localparam int unsigned DRAIN_CYC = 3 * DEPTH;
	localparam int unsigned LIMIT     = 200000;

	typedef struct {
		logic signed [KW-1:0] key;
		logic                 last;
	} key_item_t;

	typedef struct {
		logic signed [KW-1:0] key;
		logic                 is_final;
		logic                 dropped;
	} sorted_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [KW-1:0] key_value;
	logic                 end_of_batch;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [KW-1:0] sorted_key;
	logic                 final_key;
	logic                 dropped_keys;

	key_item_t   pending_keys[$];
	sorted_res_t sorted_due[$];
	key_item_t   next_item;
	sorted_res_t want;

	// Behavioural copy of the sorter's store.
	logic signed [KW-1:0] model_cells[DEPTH];
	int unsigned          model_count;
	logic                 model_overflow;

	int unsigned cycle_count = 0;
	int unsigned hold_left;
	int unsigned fail_count = 0;

	insertion_sorter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_value   (key_value),
		.end_of_batch(end_of_batch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_key  (sorted_key),
		.final_key   (final_key),
		.dropped_keys(dropped_keys)
	);

	// Inserts one key after every stored key that is not greater, and on the
	// last key of a batch queues the whole store in ascending order.
	function automatic void insert_and_flush(logic signed [KW-1:0] key, logic last);
		int unsigned pos;
		sorted_res_t res;
		if (model_count >= DEPTH) begin
			model_overflow = 1'b1;
		end else begin
			pos = model_count;
			while (pos > 0 && key < model_cells[pos-1]) begin
				model_cells[pos] = model_cells[pos-1];
				pos--;
			end
			model_cells[pos] = key;
			model_count++;
		end
		if (last) begin
			for (int unsigned i = 0; i < model_count; i++) begin
				res.key      = model_cells[i];
				res.is_final = (i + 1 == model_count);
				res.dropped  = model_overflow;
				sorted_due.push_back(res);
			end
			model_count    = 0;
			model_overflow = 1'b0;
		end
	endfunction

	// Idles with a chance of 31 in a hundred, except inside the calm window.
	function automatic logic idle_now();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 31;
	endfunction

	function automatic logic signed [KW-1:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 5)
			return $urandom;
		if (sel < 8)
			return $signed($urandom_range(8)) - 4;
		case ($urandom_range(3))
			0: return {1'b1, {(KW-1){1'b0}}};
			1: return {1'b0, {(KW-1){1'b1}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic add_key(logic signed [KW-1:0] key, logic last);
		key_item_t item;
		item.key  = key;
		item.last = last;
		pending_keys.push_back(item);
	endtask

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("insertion_sorter_unit_tb: FAIL");
			$finish;
		end
	end

	// Sender: offers queued keys, holding each one until its transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			key_value    <= '0;
			end_of_batch <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				insert_and_flush(key_value, end_of_batch);
			if (!in_valid || in_ready) begin
				if (pending_keys.size() > 0 && !idle_now()) begin
					next_item = pending_keys.pop_front();
					in_valid     <= 1'b1;
					key_value    <= next_item.key;
					end_of_batch <= next_item.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls plus one long hold-off that backs up the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (cycle_count == HOLD_AT) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_LEN;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= !idle_now();
		end
	end

	// Checker: each result transaction against the oldest predicted key.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (sorted_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual key %0d final %0b",
					$time, sorted_key, final_key);
				fail_count++;
			end else begin
				want = sorted_due.pop_front();
				if (sorted_key !== want.key) begin
					$display("%0t: sorted_key mismatch: expected %0d, actual %0d",
						$time, want.key, sorted_key);
					fail_count++;
				end
				if (final_key !== want.is_final) begin
					$display("%0t: final_key mismatch: expected %0b, actual %0b",
						$time, want.is_final, final_key);
					fail_count++;
				end
				if (dropped_keys !== want.dropped) begin
					$display("%0t: dropped_keys mismatch: expected %0b, actual %0b",
						$time, want.dropped, dropped_keys);
					fail_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned rand_count;
		int unsigned batch;
		int unsigned len;

		model_count    = 0;
		model_overflow = 1'b0;

		// Extremes of the key range, with repeats, in mixed order.
		add_key(32'sh7FFF_FFFF, 1'b0);
		add_key(32'sh8000_0000, 1'b0);
		add_key(32'sh0000_0000, 1'b0);
		add_key(32'shFFFF_FFFF, 1'b0);
		add_key(32'sh0000_0001, 1'b0);
		add_key(32'sh0000_0000, 1'b0);
		add_key(32'sh8000_0000, 1'b0);
		add_key(32'sh7FFF_FFFF, 1'b1);
		// A batch of a single key.
		add_key(32'sh5A5A_A5A5, 1'b1);
		// Equal keys around a negative one.
		add_key(3, 1'b0);
		add_key(3, 1'b0);
		add_key(-3, 1'b0);
		add_key(3, 1'b1);
		// Strictly descending, then already sorted.
		for (int k = 5; k >= 1; k--)
			add_key(k, k == 1);
		add_key(1, 1'b0);
		add_key(2, 1'b0);
		add_key(3, 1'b1);

		// Random batches; a few fill the store exactly or overrun it, and each one that
		// overruns it drops every key that arrives once the store is full.
		rand_count = 0;
		batch      = 0;
		while (rand_count < RAND_KEYS) begin
			if (batch == 2)
				len = DEPTH;
			else if (batch == 4)
				len = DEPTH + 1;
			else if (batch == 7)
				len = DEPTH + 13;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(DEPTH + 8, 20);
			else
				len = $urandom_range(10, 1);
			for (int unsigned i = 0; i < len; i++)
				add_key(pick_key(), i + 1 == len);
			rand_count += len;
			batch++;
		end

		wait (arst_n);
		wait (pending_keys.size() == 0 && !in_valid && sorted_due.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0)
			$display("insertion_sorter_unit_tb: PASS");
		else
			$display("insertion_sorter_unit_tb: FAIL");
		$finish;
	end

endmodule
